// ----- design/pfsm_pkg.sv -----
// pfsm_pkg: shared types and sizing constants for the frame stack and page map core
// used by the core and the port checker; no dependencies
`default_nettype none

package pfsm_pkg;

    localparam int STACK_DEPTH   = 4096;
    localparam int DIR_ENTRIES   = 16;
    localparam int TABLE_ENTRIES = 1024;

    localparam int VA_W    = 26;
    localparam int OFS_W   = 12;
    localparam int FRAME_W = 20;
    localparam int ENTRY_W = 32;
    localparam int FLAGS_W = 12;
    localparam int PHYS_W  = 32;

    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int STK_CW = $clog2(STACK_DEPTH + 1);

    localparam int TIX_W     = $clog2(TABLE_ENTRIES);
    localparam int DSEL_W    = VA_W - OFS_W - TIX_W;
    localparam int DIR_W     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int TBL_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int SLOT_W    = $clog2(TBL_DEPTH);

    localparam logic [FLAGS_W-1:0] FLAG_PRESENT = 12'h001;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_XLATE = 2'd2,
        OP_SEED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFRAME  = 2'd1,
        ST_UNMAPPED = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [VA_W-1:0]    virt_addr;
        logic [FLAGS_W-1:0] entry_flags;
        logic [FRAME_W-1:0] seed_frame;
    } t_req;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_addr;
        t_status           status;
    } t_rsp;

    typedef logic [DIR_W-1:0] t_dix;
    typedef logic [2**DSEL_W-1:0][DIR_W-1:0] t_dir_map;

    // upper address bits folded onto the directory, resolved at elaboration
    function automatic t_dir_map build_dir_map();
        t_dir_map m;
        for (int i = 0; i < 2**DSEL_W; i++) begin
            m[i] = t_dix'(i % DIR_ENTRIES);
        end
        return m;
    endfunction

    localparam t_dir_map DIR_MAP = build_dir_map();

endpackage

`default_nettype wire

// ----- design/pfsm_ram.sv -----
// pfsm_ram: generic simple dual port ram, one write and one registered read port
// no package dependency; used for the frame stack and the page table store
`default_nettype none

module pfsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/page_frame_stack_and_two_level_map_core.sv -----
// free frame stack and two-level page map core: sequencer, directory bits, stack pointer
// depends on pfsm_pkg and pfsm_ram
`default_nettype none

// One request at a time: seed pushes a frame number, alloc pops a frame for a missing page
// table and then one for the page, free unmaps a page and pushes its frame back, translate
// returns the physical address. Every request gives exactly one response beat. After reset
// the block clears all DIR_ENTRIES*TABLE_ENTRIES page table entries (16384 as built), one entry
// a cycle, with o_ready low. Then each request passes S_READ, the registered read of the single
// table memory, and S_EXEC, where free writes the entry back; alloc adds S_POP1 and S_DIRW for
// a missing table and S_POP2 and S_TBLW for the page, each pop a registered read of the stack
// memory. o_ready rises again as the response is handed to the output register, so a new
// request may be accepted while the previous response beat still waits.
module page_frame_stack_and_two_level_map_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pfsm_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output pfsm_pkg::t_rsp o_rsp
);
    import pfsm_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_POP1  = 9'b000010000,
        S_DIRW  = 9'b000100000,
        S_POP2  = 9'b001000000,
        S_TBLW  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [SLOT_W-1:0]      r_clr, n_clr;
    logic [STK_CW-1:0]      r_top, n_top;
    logic [DIR_ENTRIES-1:0] r_dir, n_dir;
    t_rsp                   r_res, n_res;
    t_rsp                   r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    t_op                r_op;
    logic [VA_W-1:0]    r_va;
    logic [FLAGS_W-1:0] r_flags;
    logic [FRAME_W-1:0] r_seed;

    t_dix                    dix;
    logic [TIX_W-1:0]        tix;
    logic [DIR_W+TIX_W-1:0]  slot_full;
    logic [SLOT_W-1:0]       slot;
    logic                    dir_present;
    logic                    mapped;
    logic [STK_CW-1:0]       top_m1;
    logic                    stack_empty;
    logic                    stack_full;

    logic               stk_we, stk_re;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [FRAME_W-1:0] stk_wdata, stk_rdata;

    logic               tbl_we, tbl_re;
    logic [SLOT_W-1:0]  tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;

    pfsm_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    pfsm_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (slot),
        .o_rdata (tbl_rdata)
    );

    assign dix         = DIR_MAP[r_va[VA_W-1 -: DSEL_W]];
    assign tix         = r_va[OFS_W +: TIX_W];
    assign slot_full   = {dix, tix};
    assign slot        = slot_full[SLOT_W-1:0];
    assign dir_present = r_dir[dix];
    assign mapped      = dir_present && tbl_rdata[0];
    assign top_m1      = r_top - 1'b1;
    assign stack_empty = (r_top == '0);
    assign stack_full  = (r_top == STK_CW'(STACK_DEPTH));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_top       = r_top;
        n_dir       = r_dir;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = r_top[STK_AW-1:0];
        stk_raddr = top_m1[STK_AW-1:0];
        stk_wdata = r_seed;
        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_waddr = slot;
        tbl_wdata = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SLOT_W'(TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                tbl_re  = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res.phys_addr = '0;
                n_res.status    = ST_OK;
                n_state         = S_DONE;
                case (r_op)
                    OP_ALLOC: begin
                        n_state = dir_present ? S_POP2 : S_POP1;
                    end
                    OP_FREE: begin
                        if (!mapped) begin
                            n_res.status = ST_UNMAPPED;
                        end else if (stack_full) begin
                            n_res.status = ST_OVERFLOW;
                        end else begin
                            stk_we    = 1'b1;
                            stk_wdata = tbl_rdata[ENTRY_W-1:OFS_W];
                            n_top     = r_top + 1'b1;
                            tbl_we    = 1'b1;
                        end
                    end
                    OP_XLATE: begin
                        if (!mapped) begin
                            n_res.status = ST_UNMAPPED;
                        end else begin
                            n_res.phys_addr = {tbl_rdata[ENTRY_W-1:OFS_W], r_va[OFS_W-1:0]};
                        end
                    end
                    OP_SEED: begin
                        if (stack_full) begin
                            n_res.status = ST_OVERFLOW;
                        end else begin
                            stk_we = 1'b1;
                            n_top  = r_top + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // pop for a missing table
            S_POP1: begin
                if (stack_empty) begin
                    n_res.status = ST_NOFRAME;
                    n_state      = S_DONE;
                end else begin
                    stk_re  = 1'b1;
                    n_top   = top_m1;
                    n_state = S_DIRW;
                end
            end
            S_DIRW: begin
                if (stk_rdata == '0) begin
                    n_res.status = ST_NOFRAME;
                    n_state      = S_DONE;
                end else begin
                    n_dir[dix] = 1'b1;
                    n_state    = S_POP2;
                end
            end
            // pop for the page itself; a directory entry set above stays
            S_POP2: begin
                if (stack_empty) begin
                    n_res.status = ST_NOFRAME;
                    n_state      = S_DONE;
                end else begin
                    stk_re  = 1'b1;
                    n_top   = top_m1;
                    n_state = S_TBLW;
                end
            end
            S_TBLW: begin
                n_state = S_DONE;
                if (stk_rdata == '0) begin
                    n_res.status = ST_NOFRAME;
                end else begin
                    tbl_we          = 1'b1;
                    tbl_wdata       = {stk_rdata, r_flags | FLAG_PRESENT};
                    n_res.phys_addr = {stk_rdata, {OFS_W{1'b0}}};
                    n_res.status    = ST_OK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= '0;
            r_dir       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_top       <= n_top;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op    <= i_req.op;
            r_va    <= i_req.virt_addr;
            r_flags <= i_req.entry_flags;
            r_seed  <= i_req.seed_frame;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ----- design/pfsm_chk.sv -----
// pfsm_chk: port-level checks for the frame stack and page map core, plus its bind
// depends on pfsm_pkg and page_frame_stack_and_two_level_map_core
`default_nettype none

module pfsm_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_ready,
    input wire pfsm_pkg::t_req i_req,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire pfsm_pkg::t_rsp o_rsp
);
    import pfsm_pkg::*;

    // response beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response beat changed while stalled");

    // any failed request reports a zero address
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.phys_addr == '0)
        else $error("nonzero address with error status");

    // an accepted request takes the sequencer out of idle, so o_ready is low in the cycle after
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted on two back to back cycles");

    // reset starts the table clear with both sides quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("handshake active right after reset");

endmodule

bind page_frame_stack_and_two_level_map_core pfsm_chk u_pfsm_chk (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for page_frame_stack_and_two_level_map_core
// depends on pfsm_pkg and the core rtl; holds the frame map scoreboard class and the drivers

module tb_top;
    import pfsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 500;
    localparam int POOL_SIZE      = 12;

    localparam logic [FLAGS_W-1:0] FLAG_WRITABLE = 12'h002;
    localparam logic [VA_W-1:0]    VA_HELD       = 26'h1c05000;
    localparam logic [VA_W-1:0]    VA_SPARE      = 26'h1c06000;

    class frame_map_scoreboard;
        bit [FRAME_W-1:0] free_stack [STACK_DEPTH];
        int               depth;
        bit [ENTRY_W-1:0] dir_entry  [DIR_ENTRIES];
        bit [ENTRY_W-1:0] page_entry [TBL_DEPTH];
        t_rsp             pending_rsp [$];
        int               errors;
        int               op_count [4];
        int               status_count [4];

        // empty stack hands out frame zero and stays as it is
        function bit [FRAME_W-1:0] pop_frame();
            if (depth == 0) return '0;
            depth--;
            return free_stack[depth];
        endfunction

        function bit push_frame(bit [FRAME_W-1:0] frame);
            if (depth >= STACK_DEPTH) return 1'b0;
            free_stack[depth] = frame;
            depth++;
            return 1'b1;
        endfunction

        function t_rsp walk_map(t_req r);
            int               dix;
            int               slot;
            bit [FRAME_W-1:0] frame;
            bit [ENTRY_W-1:0] flags;
            bit               mapped;
            t_rsp             rsp;
            dix    = int'(r.virt_addr[VA_W-1:OFS_W+TIX_W]) % DIR_ENTRIES;
            slot   = dix * TABLE_ENTRIES + int'(r.virt_addr[OFS_W+TIX_W-1:OFS_W]);
            flags  = ENTRY_W'(r.entry_flags);
            mapped = dir_entry[dix][0] && page_entry[slot][0];
            rsp.phys_addr = '0;
            rsp.status    = ST_OK;
            case (r.op)
                OP_ALLOC: begin
                    rsp.status = ST_NOFRAME;
                    frame      = 1;
                    if (!dir_entry[dix][0]) begin
                        frame = pop_frame();
                        if (frame != 0)
                            dir_entry[dix] = {frame, {OFS_W{1'b0}}}
                                | ENTRY_W'(FLAG_PRESENT | FLAG_WRITABLE) | flags;
                    end
                    // a table made above stays even when the page pop fails
                    if (frame != 0) begin
                        frame = pop_frame();
                        if (frame != 0) begin
                            page_entry[slot] = {frame, {OFS_W{1'b0}}}
                                | ENTRY_W'(FLAG_PRESENT) | flags;
                            rsp.phys_addr = {frame, {OFS_W{1'b0}}};
                            rsp.status    = ST_OK;
                        end
                    end
                end
                OP_FREE: begin
                    if (!mapped)
                        rsp.status = ST_UNMAPPED;
                    else if (!push_frame(page_entry[slot][ENTRY_W-1:OFS_W]))
                        rsp.status = ST_OVERFLOW;
                    else
                        page_entry[slot] = '0;
                end
                OP_XLATE: begin
                    if (!mapped)
                        rsp.status = ST_UNMAPPED;
                    else
                        rsp.phys_addr = {page_entry[slot][ENTRY_W-1:OFS_W],
                                         r.virt_addr[OFS_W-1:0]};
                end
                OP_SEED: begin
                    if (!push_frame(r.seed_frame)) rsp.status = ST_OVERFLOW;
                end
            endcase
            return rsp;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            e = walk_map(r);
            op_count[r.op]++;
            status_count[e.status]++;
            pending_rsp.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp e;
            if (pending_rsp.size() == 0) begin
                report_mismatch($sformatf("response beat with nothing expected, phys %h %s",
                                          got.phys_addr, got.status.name()));
                return;
            end
            e = pending_rsp.pop_front();
            if (got.phys_addr !== e.phys_addr)
                report_mismatch($sformatf("phys_addr %h, expected %h",
                                          got.phys_addr, e.phys_addr));
            if (got.status !== e.status)
                report_mismatch($sformatf("status %s, expected %s",
                                          got.status.name(), e.status.name()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    frame_map_scoreboard sb = new;
    int quiet_cycles = 0;
    bit hold_rsp = 1'b0;

    page_frame_stack_and_two_level_map_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_valid && o_ready) sb.note_request(i_req);
        if (o_valid && i_ready) sb.check_response(o_rsp);
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        // covers the table clear after reset and the long receiver hold-off
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("[page_frame_stack_and_two_level_map_core] ERROR");
            $finish;
        end
    end

    // receiver: stretches of always ready, coin flip, or mostly stalled
    initial begin
        int mode;
        int stretch;
        i_ready = 1'b0;
        stretch = 0;
        mode    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rsp = 1'b0;
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(5, 60);
            end
            stretch--;
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic t_req mk(t_op op, logic [VA_W-1:0] va,
                                logic [FLAGS_W-1:0] flags, logic [FRAME_W-1:0] frame);
        t_req r;
        r.op          = op;
        r.virt_addr   = va;
        r.entry_flags = flags;
        r.seed_frame  = frame;
        return r;
    endfunction

    // valid stays up into the next beat when send follows send
    task automatic send(t_req r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    initial begin
        t_req            r;
        logic [VA_W-1:0] pool [POOL_SIZE];
        int              n;
        int              k;
        int              burst;
        int              pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, empty stack, frame zero, half-built alloc, remap, free
        send(mk(OP_XLATE, '0, '0, '0));
        send(mk(OP_FREE,  '0, '0, '0));
        send(mk(OP_ALLOC, '0, 12'hfff, '0));
        send(mk(OP_SEED,  '0, '0, 20'h00000));
        send(mk(OP_ALLOC, 26'h0401000, '0, '0));
        send(mk(OP_SEED,  '0, '0, 20'hfffff));
        send(mk(OP_ALLOC, 26'h3ffffff, 12'hfff, 20'hfffff));
        send(mk(OP_SEED,  26'h3ffffff, 12'hfff, 20'h00001));
        send(mk(OP_ALLOC, 26'h3ffffff, 12'hfff, '0));
        send(mk(OP_XLATE, 26'h3ffffff, '0, '0));
        send(mk(OP_SEED,  '0, '0, 20'habcde));
        send(mk(OP_ALLOC, 26'h3fff000, 12'h000, '0));
        send(mk(OP_XLATE, 26'h3fff123, '0, '0));
        send(mk(OP_FREE,  26'h3ffffff, '0, '0));
        send(mk(OP_XLATE, 26'h3fff000, '0, '0));
        send(mk(OP_FREE,  26'h3fff000, '0, '0));
        send(mk(OP_SEED,  '0, '0, 20'h55555));
        send(mk(OP_SEED,  '0, '0, 20'haaaaa));
        send(mk(OP_ALLOC, 26'h0000000, 12'h800, '0));
        send(mk(OP_XLATE, 26'h0000abc, '0, '0));
        send(mk(OP_FREE,  26'h0400000, '0, '0));
        idle(3);

        // a small page pool keeps free and translate hitting live mappings
        for (k = 0; k < POOL_SIZE; k++) begin
            pool[k] = '0;
            pool[k][VA_W-1:OFS_W+TIX_W] = (k % 4 == 3) ? 4'hf : 4'(k % 4);
            pool[k][OFS_W+TIX_W-1:OFS_W] = TIX_W'($urandom);
        end

        n = 0;
        while (n < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 30);
            for (k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                r.op = (pick < 30) ? OP_SEED : (pick < 55) ? OP_ALLOC :
                       (pick < 75) ? OP_FREE : OP_XLATE;
                if ($urandom_range(0, 9) == 0)
                    r.virt_addr = VA_W'($urandom);
                else
                    r.virt_addr = pool[$urandom_range(0, POOL_SIZE - 1)]
                                | VA_W'($urandom_range(0, 4095));
                r.entry_flags = FLAGS_W'($urandom);
                r.seed_frame  = ($urandom_range(0, 19) == 0) ? '0 : FRAME_W'($urandom);
                if (n == 150) hold_rsp = 1'b1;
                send(r);
                n++;
                if (n == 300) begin
                    idle(1);
                    while (sb.pending_rsp.size() != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
        end

        // map one page, unmap it, then touch it and a neighbor again
        send(mk(OP_SEED,  '0, '0, 20'h12345));
        send(mk(OP_SEED,  '0, '0, 20'h23456));
        send(mk(OP_ALLOC, VA_HELD, FLAG_WRITABLE, '0));
        send(mk(OP_FREE,  VA_HELD, '0, '0));
        send(mk(OP_SEED,  '0, '0, 20'h0f0f0));
        send(mk(OP_XLATE, VA_HELD | 26'h0000fff, '0, '0));
        send(mk(OP_ALLOC, VA_SPARE, 12'h004, '0));
        send(mk(OP_FREE,  VA_HELD, '0, '0));
        idle(1);

        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("requests: %0d alloc, %0d free, %0d translate, %0d seed",
                 sb.op_count[OP_ALLOC], sb.op_count[OP_FREE],
                 sb.op_count[OP_XLATE], sb.op_count[OP_SEED]);
        $display("outcomes: %0d ok, %0d out of frames, %0d not mapped, %0d overflow",
                 sb.status_count[ST_OK], sb.status_count[ST_NOFRAME],
                 sb.status_count[ST_UNMAPPED], sb.status_count[ST_OVERFLOW]);
        if (sb.errors == 0)
            $display("[page_frame_stack_and_two_level_map_core] OK");
        else
            $display("[page_frame_stack_and_two_level_map_core] ERROR");
        $finish;
    end

endmodule
